// ===== src/caldate_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and calendar helper functions for the calendar date counter.
// Used by calendar_date_counter and caldate_info; depends on nothing else.

package caldate_pkg;

    // Year range and reset date.
    localparam logic [13:0] YEAR_MIN    = 14'd1;
    localparam logic [13:0] YEAR_MAX    = 14'd9999;
    localparam logic [13:0] RESET_YEAR  = 14'd2020;
    localparam logic [3:0]  RESET_MONTH = 4'd1;
    localparam logic [4:0]  RESET_DAY   = 5'd1;
    localparam logic [3:0]  MONTH_JAN   = 4'd1;
    localparam logic [3:0]  MONTH_FEB   = 4'd2;
    localparam logic [3:0]  MONTH_MAR   = 4'd3;
    localparam logic [3:0]  MONTH_DEC   = 4'd12;
    localparam logic [4:0]  DAY_FIRST   = 5'd1;
    localparam logic [4:0]  DAY_LAST    = 5'd31;
    localparam logic [4:0]  FEB_LEAP    = 5'd29;
    localparam logic [4:0]  FEB_COMMON  = 5'd28;
    localparam logic [4:0]  SHORT_MONTH = 5'd30;
    localparam logic [4:0]  LONG_MONTH  = 5'd31;

    // Multiplicative inverse of 25 modulo 2^14, and the largest multiple index below 2^14.
    localparam logic [13:0] INV25       = 14'd7209;
    localparam logic [13:0] DIV25_LIMIT = 14'd655;

    // Reciprocal of 100 scaled by 2^19; exact floor for any 14-bit value.
    localparam logic [12:0] RECIP100    = 13'd5243;
    localparam int          RECIP100_SH = 19;

    localparam logic [3:0]  MOD7_BASE   = 4'd7;

    // Item kinds carried in the input tuser field.
    typedef enum logic [1:0] {
        KIND_SET  = 2'd0,
        KIND_FWD  = 2'd1,
        KIND_BACK = 2'd2,
        KIND_CMP  = 2'd3
    } t_kind;

    // Compare outcome codes, two's complement.
    localparam logic [1:0] ORD_EQUAL   = 2'b00;
    localparam logic [1:0] ORD_LATER   = 2'b01;
    localparam logic [1:0] ORD_EARLIER = 2'b11;

    // Date packed in the same order as the stream data: month in the lowest bits.
    typedef struct packed {
        logic [13:0] year;
        logic [4:0]  day;
        logic [3:0]  month;
    } t_date;

    // Gregorian leap test. A year is divisible by 100 when it is divisible by 4 and 25,
    // and by 400 when it is divisible by 16 and 25. Divisibility by 25 uses the
    // modular inverse: y*inv mod 2^14 lands in the low range exactly for multiples.
    function automatic logic f_is_leap(input logic [13:0] y);
        logic [13:0] p;
        logic        div25;
        p     = y * INV25;
        div25 = (p <= DIV25_LIMIT);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    // Days in a month; months outside 1..12 fall to the default and are screened elsewhere.
    function automatic logic [4:0] f_month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2: begin
                len = leap ? FEB_LEAP : FEB_COMMON;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                len = SHORT_MONTH;
            end
            default: begin
                len = LONG_MONTH;
            end
        endcase
        return len;
    endfunction

    // Month offsets of the weekday method.
    function automatic logic [2:0] f_sak_offset(input logic [3:0] m);
        logic [2:0] off;
        case (m)
            4'd1:    off = 3'd0;
            4'd2:    off = 3'd3;
            4'd3:    off = 3'd2;
            4'd4:    off = 3'd5;
            4'd5:    off = 3'd0;
            4'd6:    off = 3'd3;
            4'd7:    off = 3'd5;
            4'd8:    off = 3'd1;
            4'd9:    off = 3'd4;
            4'd10:   off = 3'd6;
            4'd11:   off = 3'd2;
            4'd12:   off = 3'd4;
            default: off = 3'd0;
        endcase
        return off;
    endfunction

    // Remainder by 7: since 8 is 1 modulo 7, summing octal digits keeps the remainder.
    function automatic logic [2:0] f_mod7(input logic [13:0] s);
        logic [4:0] s1;
        logic [3:0] s2;
        s1 = 5'(s[2:0]) + 5'(s[5:3]) + 5'(s[8:6]) + 5'(s[11:9]) + 5'(s[13:12]);
        s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
        return (s2 >= MOD7_BASE) ? 3'(s2 - MOD7_BASE) : s2[2:0];
    endfunction

endpackage

// ===== src/caldate_info.sv =====
`timescale 1ns / 1ps
// Three-stage pipeline that derives weekday, month length and leap flag from a date.
// Depends on caldate_pkg for the date type and calendar functions.

module caldate_info import caldate_pkg::*; (
    input  logic       i_clk,
    input  logic       i_en,
    input  t_date      i_date,
    output logic [2:0] o_weekday,
    output logic [4:0] o_month_length,
    output logic       o_is_leap
);

    // First stage: shifted year, its quotient by 100, leap flag and month data.
    logic [13:0] n_yy;
    logic [26:0] n_prod;
    logic        n_leap;
    logic [13:0] r_yy;
    logic [7:0]  r_q100;
    logic [2:0]  r_off;
    logic [4:0]  r_day;
    logic        r_leap2;
    logic [4:0]  r_len2;

    // Second stage: weekday sum before reduction.
    logic [13:0] n_sum;
    logic [13:0] r_sum;
    logic        r_leap3;
    logic [4:0]  r_len3;

    // Output stage.
    logic [2:0]  r_wday;
    logic        r_leap4;
    logic [4:0]  r_len4;

    // January and February count as months of the previous year.
    always_comb begin
        n_yy   = i_date.year - ((i_date.month < MONTH_MAR) ? 14'd1 : 14'd0);
        n_prod = 27'(n_yy) * 27'(RECIP100);
        n_leap = f_is_leap(i_date.year);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_yy    <= n_yy;
            r_q100  <= n_prod[RECIP100_SH +: 8];
            r_off   <= f_sak_offset(i_date.month);
            r_day   <= i_date.day;
            r_leap2 <= n_leap;
            r_len2  <= f_month_len(i_date.month, n_leap);
        end
    end

    // y + y/4 - y/100 + y/400 + offset + day; y/400 is the quotient by 100 shifted by two.
    always_comb begin
        n_sum = r_yy + (r_yy >> 2) - 14'(r_q100) + 14'(r_q100 >> 2)
              + 14'(r_off) + 14'(r_day);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum   <= n_sum;
            r_leap3 <= r_leap2;
            r_len3  <= r_len2;
        end
    end

    // Reduce the sum modulo 7 into the output register.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wday  <= f_mod7(r_sum);
            r_leap4 <= r_leap3;
            r_len4  <= r_len3;
        end
    end

    assign o_weekday      = r_wday;
    assign o_month_length = r_len4;
    assign o_is_leap      = r_leap4;

endmodule

// ===== src/calendar_date_counter.sv =====
`timescale 1ns / 1ps
// Gregorian date counter with set, step forward, step back and compare items.
// Depends on caldate_pkg and instantiates caldate_info.

// The block holds one date (reset 2020-01-01) and takes one item per clock cycle
// while the output side is ready. Each item yields exactly one result, which
// reaches the output after the item passes the input register, the date stage
// and the three stages that derive the weekday, month length and leap flag. The
// date registers are updated directly from the registered input item, so
// back-to-back steps see each other's effect at once. The whole pipeline holds
// when a result waits and the output is not ready.
// A set with an invalid date leaves the date alone and reports set_ok low; steps
// below 0001-01-01 or above 9999-12-31 hold the date.

module calendar_date_counter import caldate_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // month_in[3:0], day_in[8:4], year_in[22:9], zero[23]
    input  logic [1:0]  i_s_tuser,   // kind[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // cur_month[3:0], cur_day[8:4], cur_year[22:9],
                                     // weekday[25:23], month_length[30:26], is_leap[31],
                                     // set_ok[32], order[34:33], zero[39:35]
);

    logic        w_adv;

    // Input register.
    logic        r_s0_valid;
    t_kind       r_s0_kind;
    t_date       r_s0_date;

    // Stored date.
    t_date       r_state;
    t_date       n_state;
    logic        n_ok;
    logic [1:0]  n_ord;

    logic        w_cur_leap;
    logic [4:0]  w_cur_len;
    logic [3:0]  w_prev_month;
    logic [4:0]  w_prev_len;
    logic        w_in_leap;
    logic [4:0]  w_in_len;
    logic        w_in_valid;
    logic        w_at_max;
    logic        w_at_min;

    // Result pipeline.
    logic        r_s1_valid;
    t_date       r_s1_date;
    logic        r_s1_ok;
    logic [1:0]  r_s1_ord;
    logic        r_s2_valid;
    t_date       r_s2_date;
    logic        r_s2_ok;
    logic [1:0]  r_s2_ord;
    logic        r_s3_valid;
    t_date       r_s3_date;
    logic        r_s3_ok;
    logic [1:0]  r_s3_ord;
    logic        r_out_valid;
    t_date       r_out_date;
    logic        r_out_ok;
    logic [1:0]  r_out_ord;

    logic [2:0]  w_weekday;
    logic [4:0]  w_month_length;
    logic        w_is_leap;

    // Every stage moves when the output register is empty or being taken.
    assign w_adv      = !r_out_valid || i_m_tready;
    assign o_s_tready = w_adv;

    // Input register: valid is control, the item itself needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_adv) begin
            r_s0_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_s_tvalid) begin
            r_s0_kind <= t_kind'(i_s_tuser);
            r_s0_date <= t_date'(i_s_tdata[22:0]);
        end
    end

    // Calendar facts of the stored date and of the incoming date.
    always_comb begin
        w_cur_leap   = f_is_leap(r_state.year);
        w_cur_len    = f_month_len(r_state.month, w_cur_leap);
        w_prev_month = r_state.month - 4'd1;
        w_prev_len   = f_month_len(w_prev_month, w_cur_leap);
        w_in_leap    = f_is_leap(r_s0_date.year);
        w_in_len     = f_month_len(r_s0_date.month, w_in_leap);
        w_in_valid   = (r_s0_date.year >= YEAR_MIN) && (r_s0_date.year <= YEAR_MAX)
                    && (r_s0_date.month >= MONTH_JAN) && (r_s0_date.month <= MONTH_DEC)
                    && (r_s0_date.day >= DAY_FIRST) && (r_s0_date.day <= w_in_len);
        w_at_max     = (r_state.year == YEAR_MAX) && (r_state.month == MONTH_DEC)
                    && (r_state.day == DAY_LAST);
        w_at_min     = (r_state.year == YEAR_MIN) && (r_state.month == MONTH_JAN)
                    && (r_state.day == DAY_FIRST);
    end

    // Next stored date, set flag and compare outcome for the item in the input register.
    always_comb begin
        n_state = r_state;
        n_ok    = 1'b0;
        n_ord   = ORD_EQUAL;
        case (r_s0_kind)
            KIND_SET: begin
                if (w_in_valid) begin
                    n_state = r_s0_date;
                    n_ok    = 1'b1;
                end
            end
            KIND_FWD: begin
                if (!w_at_max) begin
                    if (r_state.day >= w_cur_len) begin
                        n_state.day = DAY_FIRST;
                        if (r_state.month == MONTH_DEC) begin
                            n_state.month = MONTH_JAN;
                            n_state.year  = r_state.year + 14'd1;
                        end else begin
                            n_state.month = r_state.month + 4'd1;
                        end
                    end else begin
                        n_state.day = r_state.day + 5'd1;
                    end
                end
            end
            KIND_BACK: begin
                if (!w_at_min) begin
                    if (r_state.day <= DAY_FIRST) begin
                        // Going back from January lands on December 31 of the prior year.
                        if (r_state.month == MONTH_JAN) begin
                            n_state.month = MONTH_DEC;
                            n_state.year  = r_state.year - 14'd1;
                            n_state.day   = DAY_LAST;
                        end else begin
                            n_state.month = w_prev_month;
                            n_state.day   = w_prev_len;
                        end
                    end else begin
                        n_state.day = r_state.day - 5'd1;
                    end
                end
            end
            KIND_CMP: begin
                if (r_state.year != r_s0_date.year) begin
                    n_ord = (r_state.year > r_s0_date.year) ? ORD_LATER : ORD_EARLIER;
                end else if (r_state.month != r_s0_date.month) begin
                    n_ord = (r_state.month > r_s0_date.month) ? ORD_LATER : ORD_EARLIER;
                end else if (r_state.day != r_s0_date.day) begin
                    n_ord = (r_state.day > r_s0_date.day) ? ORD_LATER : ORD_EARLIER;
                end
            end
            default: begin
                n_ord = ORD_EQUAL;
            end
        endcase
    end

    // Stored date register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.year  <= RESET_YEAR;
            r_state.month <= RESET_MONTH;
            r_state.day   <= RESET_DAY;
        end else if (w_adv && r_s0_valid) begin
            r_state <= n_state;
        end
    end

    // Valid bits of the result pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= r_s0_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    // Date, set flag and compare outcome travel alongside the derived fields.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_date  <= n_state;
            r_s1_ok    <= n_ok;
            r_s1_ord   <= n_ord;
            r_s2_date  <= r_s1_date;
            r_s2_ok    <= r_s1_ok;
            r_s2_ord   <= r_s1_ord;
            r_s3_date  <= r_s2_date;
            r_s3_ok    <= r_s2_ok;
            r_s3_ord   <= r_s2_ord;
            r_out_date <= r_s3_date;
            r_out_ok   <= r_s3_ok;
            r_out_ord  <= r_s3_ord;
        end
    end

    // Weekday, month length and leap flag of the updated date.
    caldate_info u_info (
        .i_clk          (i_clk),
        .i_en           (w_adv),
        .i_date         (r_s1_date),
        .o_weekday      (w_weekday),
        .o_month_length (w_month_length),
        .o_is_leap      (w_is_leap)
    );

    // Result item.
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b00000, r_out_ord, r_out_ok, w_is_leap, w_month_length,
                         w_weekday, r_out_date};

endmodule
